FILE: rtl/msprx_pkg.sv
package msprx_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;

    // Results per frame are capped at the reach of the 6-bit byte index.
    localparam int unsigned MAX_RESULTS = 64;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOLLAR,
        PH_M,
        PH_DIR,
        PH_SIZE,
        PH_CMD
    } parse_phase_t;

    typedef enum logic [1:0] {
        DR_IDLE,
        DR_READ,
        DR_SEND
    } drain_state_t;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [7:0] data;
    } buf_write_t;

    typedef struct packed {
        logic       en;
        logic [7:0] command;
        logic [6:0] length;
        logic [6:0] count;
        logic       zero;
    } drain_start_t;

endpackage

FILE: rtl/msp_frame_receiver.sv
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_rx_byte
// m_      | out       | m_valid / m_ready  | m_command_code, m_payload_length,
//         |           |                    | m_byte_index, m_payload_byte, m_last
//
// While no frame is draining, one received byte is taken every cycle.
// A good frame drains each payload byte by a read through the single read port
// of the payload memory, then a send of its registered output (one beat if empty).
// s_ready is low during the drain; a stall on m_ready holds the current beat.
// aresetn is synchronous; it clears the parser and drain state, not the memory.
module msp_frame_receiver
    import msprx_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_command_code,
    output logic [6:0] m_payload_length,
    output logic [5:0] m_byte_index,
    output logic [7:0] m_payload_byte,
    output logic       m_last
);

    localparam int unsigned LW = $clog2(BUFFER_DEPTH + 1);

    parse_phase_t phase_reg, phase_next;
    logic [LW-1:0] exp_reg, exp_next;
    logic [LW-1:0] rcvd_reg, rcvd_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    cmd_reg, cmd_next;

    logic         accept;
    logic         busy;
    logic         size_ok;
    logic         more_payload;
    logic [8:0]   exp_wide;
    buf_write_t   wr;
    drain_start_t start;

    assign s_ready      = !busy;
    assign accept       = s_valid && s_ready;
    assign size_ok      = ({1'b0, s_rx_byte} <= 9'(BUFFER_DEPTH));
    assign more_payload = (rcvd_reg < exp_reg);
    assign exp_wide     = 9'(exp_reg);

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE:   phase_next = (s_rx_byte == CHAR_DOLLAR) ? PH_DOLLAR : PH_IDLE;
                PH_DOLLAR: phase_next = (s_rx_byte == CHAR_M) ? PH_M : PH_IDLE;
                PH_M: begin
                    phase_next = (s_rx_byte == CHAR_LT || s_rx_byte == CHAR_GT) ?
                                 PH_DIR : PH_IDLE;
                end
                PH_DIR:    phase_next = size_ok ? PH_SIZE : PH_IDLE;
                PH_SIZE:   phase_next = PH_CMD;
                PH_CMD:    phase_next = more_payload ? PH_CMD : PH_IDLE;
                default:   phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        exp_next      = exp_reg;
        rcvd_next     = rcvd_reg;
        xor_next      = xor_reg;
        cmd_next      = cmd_reg;
        wr.en         = 1'b0;
        wr.idx        = 8'(rcvd_reg);
        wr.data       = s_rx_byte;
        start.en      = 1'b0;
        start.command = cmd_reg;
        start.length  = 7'(exp_reg);
        start.count   = (exp_wide > 9'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : exp_wide[6:0];
        start.zero    = (exp_reg == '0);
        if (accept) begin
            unique case (phase_reg)
                PH_DIR: begin
                    if (size_ok) begin
                        exp_next  = s_rx_byte[LW-1:0];
                        rcvd_next = '0;
                        xor_next  = s_rx_byte;
                    end
                end
                PH_SIZE: begin
                    cmd_next = s_rx_byte;
                    xor_next = xor_reg ^ s_rx_byte;
                end
                PH_CMD: begin
                    if (more_payload) begin
                        xor_next  = xor_reg ^ s_rx_byte;
                        wr.en     = 1'b1;
                        rcvd_next = rcvd_reg + 1'b1;
                    end else begin
                        // A checksum mismatch drops the frame with no result.
                        start.en = (xor_reg == s_rx_byte);
                    end
                end
                default: wr.en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            exp_reg   <= '0;
            rcvd_reg  <= '0;
            xor_reg   <= '0;
            cmd_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            exp_reg   <= exp_next;
            rcvd_reg  <= rcvd_next;
            xor_reg   <= xor_next;
            cmd_reg   <= cmd_next;
        end
    end

    msprx_frame_buf #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_frame_buf (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr              (wr),
        .start           (start),
        .busy            (busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command_code  (m_command_code),
        .m_payload_length(m_payload_length),
        .m_byte_index    (m_byte_index),
        .m_payload_byte  (m_payload_byte),
        .m_last          (m_last)
    );

    a_rcvd_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CMD) |-> (rcvd_reg <= exp_reg))
        else $error("payload count ran past the frame size");

    a_len_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SIZE || phase_reg == PH_CMD) |->
        (exp_wide <= 9'(BUFFER_DEPTH)))
        else $error("frame size above buffer depth");

    a_idle_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        start.en |=> (phase_reg == PH_IDLE))
        else $error("parser not idle after a good checksum");

endmodule

FILE: rtl/msprx_frame_buf.sv
module msprx_frame_buf
    import msprx_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  buf_write_t   wr,
    input  drain_start_t start,
    output logic         busy,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_command_code,
    output logic [6:0]   m_payload_length,
    output logic [5:0]   m_byte_index,
    output logic [7:0]   m_payload_byte,
    output logic         m_last
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] mem [BUFFER_DEPTH];

    drain_state_t state_reg, state_next;
    logic [5:0]   idx_reg, idx_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [7:0]   cmd_reg, cmd_next;
    logic [6:0]   len_reg, len_next;
    logic         zero_reg, zero_next;
    logic [7:0]   rd_data_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    idx_wide;
    logic          last_beat;
    logic          out_fire;

    assign idx_wide  = {2'b00, idx_reg};
    assign rd_addr   = idx_wide[AW-1:0];
    assign wr_addr   = wr.idx[AW-1:0];
    assign last_beat = zero_reg || (({1'b0, idx_reg} + 7'd1) == cnt_reg);
    assign out_fire  = m_valid && m_ready;

    // The parser is held off while a frame drains, so a write and a read of
    // the same entry never fall in one cycle.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DR_IDLE: begin
                if (start.en) begin
                    state_next = start.zero ? DR_SEND : DR_READ;
                end
            end
            DR_READ: state_next = DR_SEND;
            DR_SEND: begin
                if (m_ready) begin
                    state_next = last_beat ? DR_IDLE : DR_READ;
                end
            end
            default: state_next = DR_IDLE;
        endcase
    end

    always_comb begin
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        cmd_next  = cmd_reg;
        len_next  = len_reg;
        zero_next = zero_reg;
        rd_en     = 1'b0;
        unique case (state_reg)
            DR_IDLE: begin
                if (start.en) begin
                    idx_next  = '0;
                    cnt_next  = start.count;
                    cmd_next  = start.command;
                    len_next  = start.length;
                    zero_next = start.zero;
                end
            end
            DR_READ: rd_en = 1'b1;
            DR_SEND: begin
                if (m_ready && !last_beat) begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        cmd_reg  <= cmd_next;
        len_reg  <= len_next;
        zero_reg <= zero_next;
    end

    assign busy             = (state_reg != DR_IDLE);
    assign m_valid          = (state_reg == DR_SEND);
    assign m_command_code   = cmd_reg;
    assign m_payload_length = len_reg;
    assign m_byte_index     = idx_reg;
    assign m_payload_byte   = zero_reg ? 8'd0 : rd_data_reg;
    assign m_last           = last_beat;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start.en |-> (state_reg == DR_IDLE))
        else $error("frame start while a drain is in progress");

    a_no_write_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == DR_IDLE))
        else $error("payload write while a drain is in progress");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !zero_reg) |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("byte index beyond the frame count");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_last) |=> !busy)
        else $error("drain did not end after the last beat");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && !m_last) |=> (idx_reg == $past(idx_reg) + 6'd1))
        else $error("byte index did not advance by one");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import msprx_pkg::*;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned HOLD_LEN   = 300;
    localparam int unsigned LIMIT      = 200000;
    localparam int unsigned PHASE_BEATS = 21;

    typedef struct {
        logic [7:0] command;
        logic [6:0] length;
        logic [5:0] index;
        logic [7:0] data;
        logic       last;
    } msp_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_command_code;
    logic [6:0] m_payload_length;
    logic [5:0] m_byte_index;
    logic [7:0] m_payload_byte;
    logic       m_last;

    logic [7:0]  rx_pending[$];
    msp_beat_t   payload_beats_due[$];
    msp_beat_t   beat_due;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        long_hold = 1'b0;
    int unsigned hold_count = 0;
    int unsigned holds_finished = 0;
    int unsigned cycle_count = 0;
    int unsigned err_count = 0;

    // Shadow of the frame parser.
    parse_phase_t rx_phase = PH_IDLE;
    logic [6:0]   frame_len = '0;
    logic [6:0]   got_count = '0;
    logic [7:0]   chk_acc = '0;
    logic [7:0]   cmd_hold = '0;
    logic [7:0]   payload_mem[DEPTH];

    msp_frame_receiver #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command_code  (m_command_code),
        .m_payload_length(m_payload_length),
        .m_byte_index    (m_byte_index),
        .m_payload_byte  (m_payload_byte),
        .m_last          (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic track_rx_byte(input logic [7:0] c);
        msp_beat_t b;
        case (rx_phase)
            PH_IDLE: begin
                rx_phase = (c == CHAR_DOLLAR) ? PH_DOLLAR : PH_IDLE;
            end
            PH_DOLLAR: begin
                rx_phase = (c == CHAR_M) ? PH_M : PH_IDLE;
            end
            PH_M: begin
                rx_phase = (c == CHAR_LT || c == CHAR_GT) ? PH_DIR : PH_IDLE;
            end
            PH_DIR: begin
                if (c > DEPTH) begin
                    rx_phase = PH_IDLE;
                end else begin
                    frame_len = c[6:0];
                    got_count = '0;
                    chk_acc = c;
                    rx_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                cmd_hold = c;
                chk_acc ^= c;
                rx_phase = PH_CMD;
            end
            PH_CMD: begin
                if (got_count < frame_len) begin
                    chk_acc ^= c;
                    payload_mem[got_count[5:0]] = c;
                    got_count++;
                end else begin
                    if (chk_acc == c) begin
                        b.command = cmd_hold;
                        if (frame_len == 0) begin
                            b.length = '0;
                            b.index = '0;
                            b.data = '0;
                            b.last = 1'b1;
                            payload_beats_due.push_back(b);
                        end else begin
                            for (int i = 0; i < frame_len; i++) begin
                                b.length = frame_len;
                                b.index = i[5:0];
                                b.data = payload_mem[i];
                                b.last = (i + 1 == frame_len);
                                payload_beats_due.push_back(b);
                            end
                        end
                    end
                    rx_phase = PH_IDLE;
                end
            end
            default: begin
                rx_phase = PH_IDLE;
            end
        endcase
    endtask

    // Byte driver: the prediction is updated on every accepted beat.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_rx_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                track_rx_byte(s_rx_byte);
            end
            if (!s_valid || s_ready) begin
                if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= rx_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result ready, with an optional long hold-off that backs up the parser.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_count <= 0;
        end else if (long_hold && hold_count < HOLD_LEN) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_LEN - 1) begin
                holds_finished <= holds_finished + 1;
            end
        end else begin
            if (!long_hold) begin
                hold_count <= 0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (payload_beats_due.size() == 0) begin
                $error("result beat with nothing expected: cmd %0h index %0d",
                       m_command_code, m_byte_index);
                err_count++;
            end else begin
                beat_due = payload_beats_due.pop_front();
                if (m_command_code !== beat_due.command) begin
                    $error("command_code: expected %0h, got %0h",
                           beat_due.command, m_command_code);
                    err_count++;
                end
                if (m_payload_length !== beat_due.length) begin
                    $error("payload_length: expected %0d, got %0d",
                           beat_due.length, m_payload_length);
                    err_count++;
                end
                if (m_byte_index !== beat_due.index) begin
                    $error("byte_index: expected %0d, got %0d",
                           beat_due.index, m_byte_index);
                    err_count++;
                end
                if (m_payload_byte !== beat_due.data) begin
                    $error("payload_byte: expected %0h, got %0h",
                           beat_due.data, m_payload_byte);
                    err_count++;
                end
                if (m_last !== beat_due.last) begin
                    $error("last: expected %0b, got %0b", beat_due.last, m_last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[msp_frame_receiver] ERROR");
            $finish;
        end
    end

    // Queues one frame; sizes above the buffer depth stop after the size byte.
    task automatic add_frame(input logic [7:0] dir, input int unsigned size,
                             input logic [7:0] cmd, input bit bad_chk,
                             inout int unsigned counted);
        logic [7:0] chk;
        logic [7:0] pb;
        rx_pending.push_back(CHAR_DOLLAR);
        rx_pending.push_back(CHAR_M);
        rx_pending.push_back(dir);
        rx_pending.push_back(size[7:0]);
        counted += 4;
        if (size <= DEPTH) begin
            rx_pending.push_back(cmd);
            chk = size[7:0] ^ cmd;
            for (int i = 0; i < size; i++) begin
                pb = 8'($urandom_range(255));
                chk ^= pb;
                rx_pending.push_back(pb);
            end
            if (bad_chk) begin
                chk ^= 8'($urandom_range(1, 255));
            end
            rx_pending.push_back(chk);
            counted += size + 2;
        end
    endtask

    task automatic add_random_traffic(inout int unsigned counted);
        int unsigned pick;
        int unsigned r;
        int unsigned size;
        logic [7:0]  dir;
        logic [7:0]  junk;
        pick = $urandom_range(99);
        r = $urandom_range(99);
        dir = $urandom_range(1) ? CHAR_LT : CHAR_GT;
        if (r < 85) begin
            size = $urandom_range(8);
        end else if (r < 95) begin
            size = $urandom_range(9, 63);
        end else begin
            size = DEPTH;
        end
        if (pick < 70) begin
            add_frame(dir, size, 8'($urandom_range(255)), 1'b0, counted);
        end else if (pick < 80) begin
            add_frame(dir, size, 8'($urandom_range(255)), 1'b1, counted);
        end else if (pick < 87) begin
            add_frame(dir, $urandom_range(DEPTH + 1, 255), 8'h00, 1'b0, counted);
        end else if (pick < 94) begin
            rx_pending.push_back(CHAR_DOLLAR);
            counted++;
            if ($urandom_range(1)) begin
                rx_pending.push_back(CHAR_M);
                counted++;
                do junk = 8'($urandom_range(255));
                while (junk == CHAR_LT || junk == CHAR_GT);
            end else begin
                do junk = 8'($urandom_range(255));
                while (junk == CHAR_M);
            end
            rx_pending.push_back(junk);
            counted++;
        end else begin
            // Line noise between frames; not counted.
            repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_idle();
        while (rx_pending.size() != 0 || s_valid || payload_beats_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int unsigned counted;
        int unsigned send_pcts[4];
        int unsigned stall_pcts[4];
        int unsigned holds_seen;

        send_pcts = '{0, 66, 0, 27};
        stall_pcts = '{0, 0, 66, 27};
        counted = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, a short good frame, a bad checksum, an oversize
        // length, and a second dollar sign that must not restart the header.
        add_frame(CHAR_LT, 0, 8'hFF, 1'b0, counted);
        add_frame(CHAR_GT, 1, 8'h00, 1'b0, counted);
        add_frame(CHAR_GT, 0, 8'h64, 1'b1, counted);
        add_frame(CHAR_LT, 255, 8'h00, 1'b0, counted);
        rx_pending.push_back(CHAR_DOLLAR);
        rx_pending.push_back(CHAR_DOLLAR);
        rx_pending.push_back(CHAR_M);
        wait_idle();

        // Hold the result side off while frames keep coming, so the parser
        // stalls its input behind a pending drain.
        holds_seen = holds_finished;
        long_hold = 1'b1;
        add_frame(CHAR_GT, 16, 8'($urandom_range(255)), 1'b0, counted);
        add_frame(CHAR_LT, 3, 8'($urandom_range(255)), 1'b0, counted);
        add_frame(CHAR_GT, 0, 8'($urandom_range(255)), 1'b0, counted);
        while (holds_finished == holds_seen) @(negedge aclk);
        long_hold = 1'b0;
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pcts[p];
            stall_pct = stall_pcts[p];
            counted = 0;
            while (counted < PHASE_BEATS) begin
                add_random_traffic(counted);
            end
            wait_idle();
        end

        repeat (2 * MAX_RESULTS + 20) @(negedge aclk);
        if (err_count == 0) begin
            $display("[msp_frame_receiver] OK");
        end else begin
            $display("[msp_frame_receiver] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/msprx_pkg.sv
rtl/msprx_frame_buf.sv
rtl/msp_frame_receiver.sv
dv/tb_top.sv
